@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the LFU key-value cache
// Clock and reset names follow the project convention (clock, reset).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hw/rtl/lfukv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfukv_pkg
// Shared widths, codes and types of the LFU key-value cache.
// ----------------------------------------------------------------------------
package lfukv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request kinds
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // Control of the scan accumulators
   typedef struct packed {
      logic clear;   // start of an item: drop all results
      logic step;    // one entry's stored fields are on the inputs
   } scan_ctrl_type;

endpackage

@@ hw/rtl/lfukv_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfukv_scan_unit
// Compare unit stepped over the entries one per cycle: key match, least
// frequently used victim (oldest on a tie), first free slot and fill count.
// ----------------------------------------------------------------------------
module lfukv_scan_unit import lfukv_pkg::*; #(
   parameter int  ENTRIES    = 16,
   parameter int  COUNT_BITS = 16,
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int FILL_W     = $clog2(ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]      idx,
   input  logic                  entry_valid,
   input  logic [KEY_W-1:0]      entry_key,
   input  logic [COUNT_BITS-1:0] entry_cnt,
   input  logic [IDX_W-1:0]      entry_rank,
   input  logic [KEY_W-1:0]      req_key,
   output logic                  found,
   output logic [IDX_W-1:0]      found_idx,
   output logic [COUNT_BITS-1:0] found_cnt,
   output logic [IDX_W-1:0]      found_rank,
   output logic                  victim_ok,
   output logic [IDX_W-1:0]      victim_idx,
   output logic [KEY_W-1:0]      victim_key,
   output logic [IDX_W-1:0]      victim_rank,
   output logic                  free_ok,
   output logic [IDX_W-1:0]      free_idx,
   output logic [FILL_W-1:0]     fill
);

   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [COUNT_BITS-1:0] found_cnt_ff, found_cnt_in;
   logic [IDX_W-1:0]      found_rank_ff, found_rank_in;
   logic                  victim_ok_ff, victim_ok_in;
   logic [IDX_W-1:0]      victim_idx_ff, victim_idx_in;
   logic [KEY_W-1:0]      victim_key_ff, victim_key_in;
   logic [COUNT_BITS-1:0] victim_cnt_ff, victim_cnt_in;
   logic [IDX_W-1:0]      victim_rank_ff, victim_rank_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  better;

   // Lower count wins; equal count goes to the older entry
   assign better = !victim_ok_ff || (entry_cnt < victim_cnt_ff) ||
                   ((entry_cnt == victim_cnt_ff) && (entry_rank > victim_rank_ff));

   // Accumulate over one entry
   always_comb begin
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_cnt_in   = found_cnt_ff;
      found_rank_in  = found_rank_ff;
      victim_ok_in   = victim_ok_ff;
      victim_idx_in  = victim_idx_ff;
      victim_key_in  = victim_key_ff;
      victim_cnt_in  = victim_cnt_ff;
      victim_rank_in = victim_rank_ff;
      free_ok_in     = free_ok_ff;
      free_idx_in    = free_idx_ff;
      fill_in        = fill_ff;
      priority if (ctrl.clear) begin
         found_in     = 1'b0;
         victim_ok_in = 1'b0;
         free_ok_in   = 1'b0;
         fill_in      = '0;
      end else if (ctrl.step) begin
         if (entry_valid) begin
            fill_in = fill_ff + FILL_W'(1);
            if (entry_key == req_key) begin
               found_in      = 1'b1;
               found_idx_in  = idx;
               found_cnt_in  = entry_cnt;
               found_rank_in = entry_rank;
            end
            if (better) begin
               victim_ok_in   = 1'b1;
               victim_idx_in  = idx;
               victim_key_in  = entry_key;
               victim_cnt_in  = entry_cnt;
               victim_rank_in = entry_rank;
            end
         end else if (!free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = idx;
         end
      end
   end

   // Flags and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         victim_ok_ff <= 1'b0;
         free_ok_ff   <= 1'b0;
         fill_ff      <= '0;
      end else begin
         found_ff     <= found_in;
         victim_ok_ff <= victim_ok_in;
         free_ok_ff   <= free_ok_in;
         fill_ff      <= fill_in;
      end
   end

   // Captured entry fields
   always_ff @(posedge clock) begin
      found_idx_ff   <= found_idx_in;
      found_cnt_ff   <= found_cnt_in;
      found_rank_ff  <= found_rank_in;
      victim_idx_ff  <= victim_idx_in;
      victim_key_ff  <= victim_key_in;
      victim_cnt_ff  <= victim_cnt_in;
      victim_rank_ff <= victim_rank_in;
      free_idx_ff    <= free_idx_in;
   end

   assign found       = found_ff;
   assign found_idx   = found_idx_ff;
   assign found_cnt   = found_cnt_ff;
   assign found_rank  = found_rank_ff;
   assign victim_ok   = victim_ok_ff;
   assign victim_idx  = victim_idx_ff;
   assign victim_key  = victim_key_ff;
   assign victim_rank = victim_rank_ff;
   assign free_ok     = free_ok_ff;
   assign free_idx    = free_idx_ff;
   assign fill        = fill_ff;

endmodule

@@ hw/rtl/lfu_key_value_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_key_value_cache
// Fully associative key-value cache, least frequently used replacement with
// least recently used tie break, saturating use counts.
// ----------------------------------------------------------------------------
//  channel  direction  transfer when          carries
//  req_     in         req_valid & req_ready  kind, key, value
//  rsp_     out        rsp_valid & rsp_ready  hit, read_value, evicted, evicted_key
//  csr_     in         csr_valid & csr_ready  capacity
//
//  An item goes through SCAN, DRAIN, DECIDE and FINISH; its result is offered as
//  it leaves FINISH, before the next acceptance. The scan feeds one entry per
//  cycle from the key, count and rank memories into one compare unit.
//  Reset clears the valid bits at once; no clearing pass. Capacity resets to 16.
//  A result that is not taken holds in the output register; the following
//  item is accepted and scanned meanwhile, and waits to finish until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_key_value_cache import lfukv_pkg::*; #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   // response
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_hit,
   output logic [VAL_W-1:0] rsp_read_value,
   output logic             rsp_evicted,
   output logic [KEY_W-1:0] rsp_evicted_key,
   // configuration
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_capacity
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // Entry storage
   logic [KEY_W-1:0]      key_mem  [ENTRIES];
   logic [VAL_W-1:0]      data_mem [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];
   logic [IDX_W-1:0]      rank_mem [ENTRIES];
   logic [KEY_W-1:0]      key_q;
   logic [VAL_W-1:0]      data_q;
   logic [COUNT_BITS-1:0] cnt_q;
   logic [IDX_W-1:0]      rank_q;
   logic [ENTRIES-1:0]    valid_ff, valid_in;

   // Sequencer and item registers
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             p_valid_ff, p_valid_in;
   logic [IDX_W-1:0] p_idx_ff, p_idx_in;
   logic             kind_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [CAP_W-1:0] capacity_ff;

   // Deferred recency update, applied as the next scan passes each entry
   logic             pend_valid_ff, pend_valid_in;
   logic             pend_all_ff, pend_all_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [IDX_W-1:0] pend_rank_ff, pend_rank_in;
   logic [IDX_W-1:0] rank_adj;

   // Outcome of the item
   logic             res_hit_ff, res_get_hit_ff, res_evict_ff;
   logic [KEY_W-1:0] res_ekey_ff;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [VAL_W-1:0] rsp_read_value_ff;
   logic             rsp_evicted_ff;
   logic [KEY_W-1:0] rsp_evicted_key_ff;

   // Scan unit results
   scan_ctrl_type         scan_ctrl;
   logic                  found, victim_ok, free_ok;
   logic [IDX_W-1:0]      found_idx, found_rank, victim_idx, victim_rank, free_idx;
   logic [COUNT_BITS-1:0] found_cnt;
   logic [KEY_W-1:0]      victim_key;
   logic [FILL_W-1:0]     fill;

   // Decision terms
   logic                  req_xfer, rsp_load;
   logic                  is_put, cap_zero, full;
   logic                  get_hit, put_go, put_hit, put_miss;
   logic                  evict, ins_free, insert, touch;
   logic [IDX_W-1:0]      ins_slot;
   logic [CMP_W-1:0]      cap_raw, cap_eff, ent_x;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Capacity above the store size counts as the store size
   assign ent_x    = CMP_W'(ENTRIES);
   assign cap_raw  = CMP_W'(capacity_ff);
   assign cap_eff  = (cap_raw > ent_x) ? ent_x : cap_raw;
   assign cap_zero = (cap_eff == '0);
   assign full     = (CMP_W'(fill) >= cap_eff);

   assign is_put   = (kind_ff == KIND_PUT);
   assign get_hit  = !is_put && found;
   assign put_go   = is_put && !cap_zero;
   assign put_hit  = put_go && found;
   assign put_miss = put_go && !found;
   assign evict    = put_miss && full && victim_ok;
   assign ins_free = put_miss && !evict && free_ok;
   assign insert   = evict || ins_free;
   assign touch    = get_hit || put_hit;
   assign ins_slot = evict ? victim_idx : free_idx;
   assign cnt_inc  = (found_cnt == '1) ? found_cnt : found_cnt + COUNT_BITS'(1);

   // Rank as seen after the previous item's update
   always_comb begin
      rank_adj = rank_q;
      if (pend_valid_ff && valid_ff[p_idx_ff]) begin
         priority if (p_idx_ff == pend_slot_ff) begin
            rank_adj = '0;
         end else if (pend_all_ff || (rank_q < pend_rank_ff)) begin
            rank_adj = rank_q + IDX_W'(1);
         end
      end
   end

   assign scan_ctrl.clear = req_xfer;
   assign scan_ctrl.step  = p_valid_ff;

   lfukv_scan_unit #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .idx         (p_idx_ff),
      .entry_valid (valid_ff[p_idx_ff]),
      .entry_key   (key_q),
      .entry_cnt   (cnt_q),
      .entry_rank  (rank_adj),
      .req_key     (key_ff),
      .found       (found),
      .found_idx   (found_idx),
      .found_cnt   (found_cnt),
      .found_rank  (found_rank),
      .victim_ok   (victim_ok),
      .victim_idx  (victim_idx),
      .victim_key  (victim_key),
      .victim_rank (victim_rank),
      .free_ok     (free_ok),
      .free_idx    (free_idx),
      .fill        (fill)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_all_in   = pend_all_ff;
      pend_slot_in  = pend_slot_ff;
      pend_rank_in  = pend_rank_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            p_valid_in = 1'b1;
            p_idx_in   = idx_ff;
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Old update is now in memory; record this item's
            pend_valid_in = touch || insert;
            pend_all_in   = ins_free;
            pend_slot_in  = touch ? found_idx : ins_slot;
            pend_rank_in  = touch ? found_rank : victim_rank;
            if (insert) begin
               valid_in[ins_slot] = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         p_valid_ff    <= 1'b0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= CAP_RESET;
      end else begin
         state_ff      <= state_in;
         p_valid_ff    <= p_valid_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      p_idx_ff     <= p_idx_in;
      pend_all_ff  <= pend_all_in;
      pend_slot_ff <= pend_slot_in;
      pend_rank_ff <= pend_rank_in;
      if (req_xfer) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (state_ff == ST_DECIDE) begin
         res_hit_ff     <= touch;
         res_get_hit_ff <= get_hit;
         res_evict_ff   <= evict;
         res_ekey_ff    <= evict ? victim_key : '0;
      end
      if (rsp_load) begin
         rsp_hit_ff         <= res_hit_ff;
         rsp_read_value_ff  <= res_get_hit_ff ? data_q : '0;
         rsp_evicted_ff     <= res_evict_ff;
         rsp_evicted_key_ff <= res_ekey_ff;
      end
   end

   // Scan reads and rank write-back
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) begin
         key_q  <= key_mem[idx_ff];
         cnt_q  <= cnt_mem[idx_ff];
         rank_q <= rank_mem[idx_ff];
      end
      if (p_valid_ff) begin
         rank_mem[p_idx_ff] <= rank_adj;
      end
   end

   // Entry updates at the decision step
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         if (!is_put) begin
            data_q <= data_mem[found_idx];
         end
         if (touch) begin
            cnt_mem[found_idx] <= cnt_inc;
         end
         if (put_hit) begin
            data_mem[found_idx] <= value_ff;
         end
         if (insert) begin
            key_mem[ins_slot]  <= key_ff;
            data_mem[ins_slot] <= value_ff;
            cnt_mem[ins_slot]  <= COUNT_BITS'(1);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   // Checks
   `ASSERT_NEXT(a_accept_scans, req_xfer, state_ff == ST_SCAN, "no scan after accept")
   `ASSERT_IMPL(a_pend_slot_valid, pend_valid_ff, valid_ff[pend_slot_ff], "pending slot empty")
   `ASSERT_NEXT(a_valid_sticky, 1'b1, &(valid_ff | ~$past(valid_ff)), "valid bit lost")
   `ASSERT_IMPL(a_evict_not_hit, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff, "evict on hit")

endmodule
